[sv/shuffled_minimal_standard_rng_core_macros.svh]
// Assertion macros for the shuffled minimal-standard generator core.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef SHUFFLED_MINIMAL_STANDARD_RNG_CORE_MACROS_SVH
`define SHUFFLED_MINIMAL_STANDARD_RNG_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/smsr_pkg.sv]
// Shared constants and types for the shuffled minimal-standard generator.
// No dependencies; compile first after the macro header.
`default_nettype none

package smsr_pkg;

    // Shuffle table size; must be a power of two between 2 and 256.
    localparam int TABLE_SIZE = 32;
    localparam int TAB_AW     = $clog2(TABLE_SIZE);
    localparam int WARM_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(WARM_STEPS);

    localparam int STATE_W = 32;
    localparam int DEV_W   = 31;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = STATE_W + MULT_W;

    localparam logic [MULT_W-1:0]         MULT       = 15'd16807;
    localparam logic [DEV_W-1:0]          MODULUS    = 31'h7FFF_FFFF;
    localparam logic signed [STATE_W-1:0] SEED_RESET = 32'sd17;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD
    } smsr_state_t;

endpackage

`default_nettype wire

[sv/shuffled_minimal_standard_rng_core.sv]
// Top level of the shuffled minimal-standard generator (multiplier 16807 modulo 2^31-1,
// Bays-Durham shuffle). Depends on smsr_pkg, smsr_ram and the macro header.
// Sequential FSM around one table RAM; assertions at the end.
`default_nettype none

// Usage: each accepted beat on the input channel with draw high yields one deviate
// beat in 0..2^31-2 (divide by 2^31-1 for a uniform fraction); a beat with draw low
// is taken and dropped. In a steady-state draw the accept cycle
// multiplies the state by 16807 into a product register, the next cycle folds it
// modulo 2^31-1 (one add and one compare-subtract) while the shuffle table RAM,
// read in the accept cycle, supplies the outgoing entry and takes the new state in
// the same slot. A draw that must warm up (last deviate zero, as after reset, state not
// positive, or a negative seed) first runs TABLE_SIZE+8 generator steps, each a
// multiply and a fold, then the normal draw. The seed register is written through
// its own channel, which is always ready, and takes effect on the next draw. A
// finished deviate waits in an output register, so a new draw is taken while it is
// still unclaimed; only the fold cycle stalls when that register is still full.
module shuffled_minimal_standard_rng_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic signed [smsr_pkg::STATE_W-1:0]   cfg_seed,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  draw,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic             [smsr_pkg::DEV_W-1:0]     deviate
);

    import smsr_pkg::*;

    `include "shuffled_minimal_standard_rng_core_macros.svh"

    // Control and state registers
    smsr_state_t                state_reg, state_next;
    logic                       warm_reg,  warm_next;
    logic [CNT_W-1:0]           cnt_reg,   cnt_next;
    logic                       pend_reg,  pend_next;
    logic signed [STATE_W-1:0]  seed_reg,  seed_next;
    logic [STATE_W-1:0]         cur_reg,   cur_next;
    logic [DEV_W-1:0]           last_reg,  last_next;
    logic [PROD_W-1:0]          prod_reg,  prod_next;
    logic                       out_valid_reg, out_valid_next;
    logic [DEV_W-1:0]           out_data_reg,  out_data_next;

    // Datapath
    logic signed [STATE_W-1:0]  st_eff;
    logic                       start_warm;
    logic [STATE_W-1:0]         x_sel;
    logic [STATE_W-1:0]         mul_a;
    logic [STATE_W-1:0]         fold_sum;
    logic [DEV_W-1:0]           fold_val;
    logic [TAB_AW-1:0]          slot;
    logic                       in_fire;
    logic                       cfg_fire;
    logic                       out_free;

    // Table RAM
    logic                       ram_we;
    logic [TAB_AW-1:0]          ram_waddr;
    logic [DEV_W-1:0]           ram_wdata;
    logic                       ram_re;
    logic [DEV_W-1:0]           ram_rdata;

    smsr_ram #(
        .WIDTH (DEV_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign deviate   = out_data_reg;

    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Slot comes from the top bits of the previous output.
    assign slot = last_reg[DEV_W-1 -: TAB_AW];

    // Pick up the seed on the first draw after it was written, then decide on warm-up.
    always_comb
    begin
        st_eff     = pend_reg ? seed_reg : $signed(cur_reg);
        start_warm = (st_eff <= 0) || (last_reg == '0);
        if (!start_warm)
        begin
            x_sel = st_eff;
        end
        else if (!st_eff[STATE_W-1])
        begin
            x_sel = STATE_W'(1);
        end
        else
        begin
            // Negation of the most negative seed gives 2^31, read as unsigned.
            x_sel = STATE_W'(-st_eff);
        end
    end

    assign mul_a = (state_reg == ST_IDLE) ? x_sel : cur_reg;

    // Modulo 2^31-1: add the high part onto the low 31 bits, then one subtract.
    always_comb
    begin
        fold_sum = {1'b0, prod_reg[DEV_W-1:0]} + STATE_W'(prod_reg[PROD_W-1:DEV_W]);
        if (fold_sum >= {1'b0, MODULUS})
        begin
            fold_val = DEV_W'(fold_sum - {1'b0, MODULUS});
        end
        else
        begin
            fold_val = fold_sum[DEV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            warm_reg      <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b1;
            seed_reg      <= SEED_RESET;
            cur_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            warm_reg      <= warm_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            seed_reg      <= seed_next;
            cur_reg       <= cur_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        warm_next      = warm_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        seed_next      = seed_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot;
        ram_wdata      = fold_val;
        ram_re         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && draw)
                begin
                    // Multiply now; read the outgoing slot unless a warm-up comes first.
                    pend_next  = 1'b0;
                    prod_next  = PROD_W'(mul_a) * PROD_W'(MULT);
                    warm_next  = start_warm;
                    cnt_next   = CNT_W'(WARM_STEPS - 1);
                    ram_re     = !start_warm;
                    state_next = ST_FOLD;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(MULT);
                ram_re     = !warm_reg;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (warm_reg)
                begin
                    // Warm-up step: the last TABLE_SIZE steps fill the table, top slot first.
                    cur_next  = STATE_W'(fold_val);
                    ram_waddr = cnt_reg[TAB_AW-1:0];
                    ram_we    = (cnt_reg < CNT_W'(TABLE_SIZE));
                    if (cnt_reg == '0)
                    begin
                        last_next = fold_val;
                        warm_next = 1'b0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    state_next = ST_MUL;
                end
                else if (out_free)
                begin
                    // Swap: old slot entry goes out, fresh state takes its place.
                    cur_next       = STATE_W'(fold_val);
                    last_next      = ram_rdata;
                    ram_we         = 1'b1;
                    out_data_next  = ram_rdata;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_fire)
        begin
            seed_next = cfg_seed;
            pend_next = 1'b1;
        end
    end

    // The write of one draw lands before the next draw can read the table, so
    // table accesses never collide and need no forwarding.

    `SMSR_ASSERT_NOW(a_state_in_range, 1'b1, !cur_reg[STATE_W-1] && (cur_reg[DEV_W-1:0] != MODULUS), "generator state left 0..2^31-2")
    `SMSR_ASSERT_NOW(a_stall_no_write, (state_reg == ST_FOLD) && !warm_reg && !out_free, !ram_we && (state_next == ST_FOLD), "table written while the output register is full")
    `SMSR_ASSERT_NEXT(a_swap_delivers, (state_reg == ST_FOLD) && !warm_reg && out_free, out_valid_reg && (deviate == last_reg) && (state_reg == ST_IDLE), "table swap did not deliver a deviate")

endmodule

`default_nettype wire

[sv/smsr_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; read data holds while no read is enabled.
`default_nettype none

module smsr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[tb/deviate_checker.sv]
// Scoreboard for the shuffled minimal-standard generator core: predicts each deviate
// and compares it with the output beats. Depends on smsr_pkg for widths and constants.
module deviate_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    input  wire logic                                 cfg_ready,
    input  wire logic signed [smsr_pkg::STATE_W-1:0]  cfg_seed,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic                                 draw,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic        [smsr_pkg::DEV_W-1:0]    deviate,
    output int                                        mismatches,
    output int                                        pending
);

    localparam longint PRIME      = longint'(smsr_pkg::MODULUS);
    localparam longint MULTIPLIER = longint'(smsr_pkg::MULT);
    localparam longint SLOT_SPAN  = 1 + (PRIME - 1) / smsr_pkg::TABLE_SIZE;
    localparam int     REPORT_MAX = 10;

    logic signed [smsr_pkg::STATE_W-1:0] seed_reg;
    logic                                seed_armed;
    logic signed [smsr_pkg::STATE_W-1:0] gen_state;
    logic        [smsr_pkg::DEV_W-1:0]   last_dev;
    logic        [smsr_pkg::DEV_W-1:0]   shuffle [smsr_pkg::TABLE_SIZE];
    logic        [smsr_pkg::DEV_W-1:0]   deviate_due [$];
    logic        [smsr_pkg::DEV_W-1:0]   want;

    // x * 16807 mod (2^31 - 1); x stays within [0, 2^31].
    function automatic longint mul_mod_prime(input longint x);
        return (x * MULTIPLIER) % PRIME;
    endfunction

    // Warm up if due, then advance once and shuffle the fresh value into the table.
    function automatic logic [smsr_pkg::DEV_W-1:0] next_deviate();
        longint st;
        longint slot;
        int     k;
        if (seed_armed)
        begin
            gen_state  = seed_reg;
            seed_armed = 1'b0;
        end
        st = gen_state;
        if (st <= 0 || last_dev == '0)
        begin
            st = (st >= 0) ? 64'sd1 : -st;
            for (k = smsr_pkg::TABLE_SIZE + 7; k >= 0; k--)
            begin
                st = mul_mod_prime(st);
                if (k < smsr_pkg::TABLE_SIZE)
                    shuffle[k] = st[smsr_pkg::DEV_W-1:0];
            end
            last_dev = shuffle[0];
        end
        st        = mul_mod_prime(st);
        gen_state = st[smsr_pkg::STATE_W-1:0];
        slot      = last_dev / SLOT_SPAN;
        if (slot >= smsr_pkg::TABLE_SIZE)
            slot = smsr_pkg::TABLE_SIZE - 1;
        last_dev      = shuffle[slot];
        shuffle[slot] = st[smsr_pkg::DEV_W-1:0];
        return last_dev;
    endfunction

    // Sample at the falling edge: what holds here is what the next rising edge takes.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            seed_reg   = smsr_pkg::SEED_RESET;
            seed_armed = 1'b1;
            gen_state  = '0;
            last_dev   = '0;
            foreach (shuffle[i])
                shuffle[i] = '0;
            deviate_due.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (deviate_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("checker: deviate %0d with no draw outstanding", deviate);
                end
                else
                begin
                    want = deviate_due.pop_front();
                    if (deviate !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("checker: deviate expected %0d, got %0d", want, deviate);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                seed_reg   = cfg_seed;
                seed_armed = 1'b1;
            end
            if (in_valid && in_ready && draw)
                deviate_due.push_back(next_deviate());
        end
        pending = deviate_due.size();
    end

endmodule

[tb/shuffled_minimal_standard_rng_core_test.sv]
// Top of the generator core testbench: clock, reset, stimulus, flow control and verdict.
// Depends on smsr_pkg, the core itself and deviate_checker.
module shuffled_minimal_standard_rng_core_test;

    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_DRAWS = 180;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1_000_000;
    // One full warm-up plus a normal draw, with margin.
    localparam int SETTLE_CYCLES = 2 * (smsr_pkg::WARM_STEPS + 1) + 20;

    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 53;
    localparam int IDLE_BOTH  = 28;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic signed [smsr_pkg::STATE_W-1:0] cfg_seed  = '0;
    logic                                in_valid  = 1'b0;
    logic                                draw      = 1'b0;
    logic                                out_ready = 1'b0;
    logic                                hold_req  = 1'b0;
    wire  logic                          cfg_ready;
    wire  logic                          in_ready;
    wire  logic                          out_valid;
    wire  logic  [smsr_pkg::DEV_W-1:0]   deviate;

    int mismatches;
    int pending;
    int send_idle_pct = IDLE_NONE;
    int stall_pct     = IDLE_NONE;
    int hold_left     = 0;
    int cycle_count   = 0;

    shuffled_minimal_standard_rng_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_seed  (cfg_seed),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .draw      (draw),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .deviate   (deviate)
    );

    deviate_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_seed   (cfg_seed),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .draw       (draw),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .deviate    (deviate),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // Give up if the run hangs; a healthy run ends far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("shuffled_minimal_standard_rng_core: mismatch");
            $finish;
        end
    end

    // Output side. A pulse on hold_req starts a long hold-off, counted here, that lets
    // the core fill up and push back on the input; otherwise stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one input beat and return at the edge that accepts it. Idle first at
    // random; keep valid and draw steady once raised.
    task automatic send_beat(input logic want_draw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        draw     <= want_draw;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
    endtask

    task automatic send_draws(input int count);
        repeat (count)
            send_beat(1'b1);
    endtask

    // Write the seed only once the core is idle: drain every outstanding deviate,
    // then wait out the settle time as a margin.
    task automatic write_seed(input logic signed [smsr_pkg::STATE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_seed  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int   seg;
        int   done;
        logic want_draw;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. Start from the reset seed: the first draw warms
        // up, later ones step a positive state; a beat with draw low is dropped.
        send_beat(1'b1);
        send_beat(1'b0);
        send_draws(2);

        // Zero seed: warm up from state one.
        write_seed('0);
        send_draws(2);

        // Seed equal to the modulus: the first draw steps to state zero without a
        // warm-up (table already filled), the next one warms up from one.
        write_seed(32'sh7FFF_FFFF);
        send_draws(3);

        // Most negative seed: negation overflows 32 bits and must be stepped exactly.
        write_seed(32'sh8000_0000);
        send_draws(2);

        // All-ones seed (-1), then the largest valid state, then the smallest one.
        write_seed(-32'sd1);
        send_draws(2);
        write_seed(32'sh7FFF_FFFE);
        send_draws(2);
        write_seed(32'sd1);
        send_draws(2);

        // Random part: pairs of segments per idling mode, a fresh seed for each.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle_pct = IDLE_NONE;
                    stall_pct    <= IDLE_NONE;
                end
                1:
                begin
                    send_idle_pct = IDLE_HEAVY;
                    stall_pct    <= IDLE_NONE;
                end
                2:
                begin
                    send_idle_pct = IDLE_NONE;
                    stall_pct    <= IDLE_HEAVY;
                end
                default:
                begin
                    send_idle_pct = IDLE_BOTH;
                    stall_pct    <= IDLE_BOTH;
                end
            endcase

            case (seg)
                3:       write_seed(32'sh7FFF_FFFF);
                5:       write_seed(32'sh8000_0000);
                6:       write_seed(-$signed({1'b0, 31'($urandom())}));
                default: write_seed($urandom());
            endcase

            // Hold off the output for a long stretch while the input keeps coming.
            if (seg == 1)
            begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end

            done = 0;
            while (done < SEGMENT_DRAWS)
            begin
                want_draw = ($urandom_range(9) != 0);
                send_beat(want_draw);
                if (want_draw)
                    done++;
            end
        end

        // Drain, then let any late or stray beat show up before the verdict.
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("shuffled_minimal_standard_rng_core: match");
        else
            $display("shuffled_minimal_standard_rng_core: mismatch");
        $finish;
    end

endmodule
